FILE: hdl/fwtk_pkg.sv
// shared constants and controller/datapath interface types of the fuzzy window classifier
`timescale 1ns / 1ps
package fwtk_pkg;

  // table and field geometry
  localparam int DEF_MAX_ENTRIES  = 16;
  localparam int TOP_SLOTS        = 4;
  localparam int SAMPLE_BITS      = 32;
  localparam int PARAMS_PER_ENTRY = 13;
  localparam int PRIORITY_SEL     = 12;
  localparam int DIMS             = 4;
  localparam int DIM_W            = 2;
  localparam int SLOT_W           = 2;
  localparam int CNT_W            = 3;
  localparam int IDX_W            = 4;
  localparam int SEL_W            = 4;
  localparam int CFG_W            = 5;
  localparam int NW_W             = 16;

  // arithmetic widths
  localparam int Q16_W     = 17;
  localparam int EXT_W     = SAMPLE_BITS + 2;
  localparam int DIV_W     = SAMPLE_BITS + 2;
  localparam int TOTAL_W   = SAMPLE_BITS + 1;
  localparam int DIV_STEPS = 17;
  localparam int STEP_W    = 5;
  localparam logic [Q16_W-1:0] ONE_Q16 = 17'h10000;
  localparam logic [17:0] SMOOTH_K = 18'd196608;

  // stream payload widths
  localparam int IN_DATA_W  = 168;
  localparam int OUT_DATA_W = 88;

  // controller to datapath commands
  typedef struct packed {
    logic             wr;
    logic             start;
    logic [DIM_W-1:0] dim;
    logic [SEL_W-1:0] sel;
    logic             rd;
    logic             ld_min;
    logic             ld_max;
    logic             ld_bl;
    logic             hard;
    logic             phase;
    logic             ramp_sat;
    logic             div_ramp;
    logic             div_norm;
    logic             div_step;
    logic             sq;
    logic             smooth;
    logic             ramp_end;
    logic             mw;
    logic             chain;
    logic             m_init;
    logic             weight;
    logic             insert;
    logic             sum_add;
    logic [SLOT_W-1:0] slot;
    logic             norm_store;
    logic             norm_zero;
    logic             out_load;
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic             bl_pos;
    logic             ramp_low;
    logic             ramp_high;
    logic             chain_zero;
    logic [CNT_W-1:0] count;
    logic             out_free;
  } dp_status_t;

endpackage

FILE: hdl/fwtk_ctrl.sv
// sequencer that walks entries, dimensions, ramps and normalization slots
`timescale 1ns / 1ps
module fwtk_ctrl #(
  parameter int MAX_ENTRIES = fwtk_pkg::DEF_MAX_ENTRIES,
  parameter int EW          = $clog2(MAX_ENTRIES + 1)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         opcode_i,
  input  logic [fwtk_pkg::CFG_W-1:0]   cfg_count_i,
  input  fwtk_pkg::dp_status_t         status_i,
  output fwtk_pkg::dp_cmd_t            cmd_o,
  output logic [EW-1:0]                entry_o
);
  import fwtk_pkg::*;

  localparam logic [4:0] S_IDLE     = 5'd0;
  localparam logic [4:0] S_RD_MIN   = 5'd1;
  localparam logic [4:0] S_RD_MAX   = 5'd2;
  localparam logic [4:0] S_RD_BL    = 5'd3;
  localparam logic [4:0] S_LD_BL    = 5'd4;
  localparam logic [4:0] S_CHK      = 5'd5;
  localparam logic [4:0] S_RAMP     = 5'd6;
  localparam logic [4:0] S_DIV      = 5'd7;
  localparam logic [4:0] S_SQ       = 5'd8;
  localparam logic [4:0] S_SMOOTH   = 5'd9;
  localparam logic [4:0] S_RAMP_END = 5'd10;
  localparam logic [4:0] S_MW       = 5'd11;
  localparam logic [4:0] S_CHAIN    = 5'd12;
  localparam logic [4:0] S_RD_PRIO  = 5'd13;
  localparam logic [4:0] S_WEIGHT   = 5'd14;
  localparam logic [4:0] S_INSERT   = 5'd15;
  localparam logic [4:0] S_NEXT     = 5'd16;
  localparam logic [4:0] S_SUM      = 5'd17;
  localparam logic [4:0] S_NORM     = 5'd18;
  localparam logic [4:0] S_NDIV     = 5'd19;
  localparam logic [4:0] S_NSTORE   = 5'd20;
  localparam logic [4:0] S_DONE     = 5'd21;

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TOP_SLOTS - 1);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIV_STEPS - 1);
  localparam logic [DIM_W-1:0]  LAST_DIM  = DIM_W'(DIMS - 1);

  logic [4:0]        state_q, state_d;
  logic [EW-1:0]     e_q, e_d, n_q, n_d, n_cap;
  logic [DIM_W-1:0]  d_q, d_d;
  logic [SLOT_W-1:0] k_q, k_d;
  logic [STEP_W-1:0] cnt_q, cnt_d;
  logic              phase_q, phase_d;
  logic [SEL_W-1:0]  sel_base;

  // entry count limited to the table depth
  assign n_cap    = (32'(cfg_count_i) > 32'(MAX_ENTRIES)) ? EW'(MAX_ENTRIES) : EW'(cfg_count_i);
  assign sel_base = SEL_W'(d_q) * SEL_W'(3);
  assign entry_o  = e_q;

  // next state and command decode
  always_comb begin
    state_d    = state_q;
    e_d        = e_q;
    n_d        = n_q;
    d_d        = d_q;
    k_d        = k_q;
    cnt_d      = cnt_q;
    phase_d    = phase_q;
    cmd_o      = '0;
    cmd_o.dim  = d_q;
    cmd_o.slot = k_q;
    cmd_o.phase = phase_q;
    in_ready_o = (state_q == S_IDLE);
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (!opcode_i) begin
            cmd_o.wr = 1'b1;
          end else begin
            cmd_o.start = 1'b1;
            e_d = '0;
            d_d = '0;
            k_d = '0;
            n_d = n_cap;
            state_d = (n_cap == '0) ? S_SUM : S_RD_MIN;
          end
        end
      end
      S_RD_MIN: begin
        cmd_o.rd  = 1'b1;
        cmd_o.sel = sel_base;
        state_d   = S_RD_MAX;
      end
      S_RD_MAX: begin
        cmd_o.rd     = 1'b1;
        cmd_o.sel    = sel_base + SEL_W'(1);
        cmd_o.ld_min = 1'b1;
        state_d      = S_RD_BL;
      end
      S_RD_BL: begin
        cmd_o.rd     = 1'b1;
        cmd_o.sel    = sel_base + SEL_W'(2);
        cmd_o.ld_max = 1'b1;
        state_d      = S_LD_BL;
      end
      S_LD_BL: begin
        cmd_o.ld_bl = 1'b1;
        state_d     = S_CHK;
      end
      S_CHK: begin
        if (!status_i.bl_pos) begin
          cmd_o.hard = 1'b1;
          state_d    = S_CHAIN;
        end else begin
          phase_d = 1'b0;
          state_d = S_RAMP;
        end
      end
      S_RAMP: begin
        if (status_i.ramp_low || status_i.ramp_high) begin
          cmd_o.ramp_sat = 1'b1;
          state_d        = S_RAMP_END;
        end else begin
          cmd_o.div_ramp = 1'b1;
          cnt_d          = '0;
          state_d        = S_DIV;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d = cnt_q + STEP_W'(1);
        if (cnt_q == LAST_STEP) state_d = S_SQ;
      end
      S_SQ: begin
        cmd_o.sq = 1'b1;
        state_d  = S_SMOOTH;
      end
      S_SMOOTH: begin
        cmd_o.smooth = 1'b1;
        state_d      = S_RAMP_END;
      end
      S_RAMP_END: begin
        cmd_o.ramp_end = 1'b1;
        if (!phase_q) begin
          phase_d = 1'b1;
          state_d = S_RAMP;
        end else begin
          state_d = S_MW;
        end
      end
      S_MW: begin
        cmd_o.mw = 1'b1;
        state_d  = S_CHAIN;
      end
      S_CHAIN: begin
        cmd_o.chain = 1'b1;
        if (status_i.chain_zero) begin
          state_d = S_NEXT;
        end else if (d_q == LAST_DIM) begin
          state_d = S_RD_PRIO;
        end else begin
          d_d     = d_q + DIM_W'(1);
          state_d = S_RD_MIN;
        end
      end
      S_RD_PRIO: begin
        cmd_o.rd  = 1'b1;
        cmd_o.sel = SEL_W'(PRIORITY_SEL);
        state_d   = S_WEIGHT;
      end
      S_WEIGHT: begin
        cmd_o.weight = 1'b1;
        state_d      = S_INSERT;
      end
      S_INSERT: begin
        cmd_o.insert = 1'b1;
        state_d      = S_NEXT;
      end
      S_NEXT: begin
        cmd_o.m_init = 1'b1;
        d_d = '0;
        e_d = e_q + EW'(1);
        if (e_q + EW'(1) == n_q) begin
          k_d     = '0;
          state_d = S_SUM;
        end else begin
          state_d = S_RD_MIN;
        end
      end
      S_SUM: begin
        cmd_o.sum_add = 1'b1;
        if (k_q == LAST_SLOT) begin
          k_d     = '0;
          state_d = S_NORM;
        end else begin
          k_d = k_q + SLOT_W'(1);
        end
      end
      S_NORM: begin
        if (CNT_W'(k_q) >= status_i.count) begin
          cmd_o.norm_zero = 1'b1;
          if (k_q == LAST_SLOT) state_d = S_DONE;
          else k_d = k_q + SLOT_W'(1);
        end else begin
          cmd_o.div_norm = 1'b1;
          cnt_d          = '0;
          state_d        = S_NDIV;
        end
      end
      S_NDIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d = cnt_q + STEP_W'(1);
        if (cnt_q == LAST_STEP) state_d = S_NSTORE;
      end
      S_NSTORE: begin
        cmd_o.norm_store = 1'b1;
        if (k_q == LAST_SLOT) begin
          state_d = S_DONE;
        end else begin
          k_d     = k_q + SLOT_W'(1);
          state_d = S_NORM;
        end
      end
      S_DONE: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      e_q     <= '0;
      n_q     <= '0;
      d_q     <= '0;
      k_q     <= '0;
      cnt_q   <= '0;
      phase_q <= 1'b0;
    end else begin
      state_q <= state_d;
      e_q     <= e_d;
      n_q     <= n_d;
      d_q     <= d_d;
      k_q     <= k_d;
      cnt_q   <= cnt_d;
      phase_q <= phase_d;
    end
  end

endmodule

FILE: hdl/fwtk_datapath.sv
// parameter table, membership arithmetic, shared divider, ranking and output register
`timescale 1ns / 1ps
module fwtk_datapath #(
  parameter int MAX_ENTRIES = fwtk_pkg::DEF_MAX_ENTRIES,
  parameter int EW          = $clog2(MAX_ENTRIES + 1)
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  fwtk_pkg::dp_cmd_t                      cmd_i,
  input  logic [EW-1:0]                          entry_i,
  output fwtk_pkg::dp_status_t                   status_o,
  input  logic [fwtk_pkg::IDX_W-1:0]             entry_index_i,
  input  logic [fwtk_pkg::SEL_W-1:0]             param_select_i,
  input  logic signed [fwtk_pkg::SAMPLE_BITS-1:0] param_value_i,
  input  logic signed [fwtk_pkg::SAMPLE_BITS-1:0] temperature_i,
  input  logic signed [fwtk_pkg::SAMPLE_BITS-1:0] humidity_i,
  input  logic signed [fwtk_pkg::SAMPLE_BITS-1:0] elevation_i,
  input  logic signed [fwtk_pkg::SAMPLE_BITS-1:0] steepness_i,
  input  logic                                   out_ready_i,
  output logic                                   out_valid_o,
  output logic [fwtk_pkg::OUT_DATA_W-1:0]        out_data_o
);
  import fwtk_pkg::*;

  localparam int DEPTH  = MAX_ENTRIES * PARAMS_PER_ENTRY;
  localparam int ADDR_W = $clog2(DEPTH);

  logic [SAMPLE_BITS-1:0]          mem [DEPTH];
  logic signed [SAMPLE_BITS-1:0]   rdata_q;
  logic [ADDR_W-1:0]               waddr, raddr;
  logic                            wr_en;

  logic signed [SAMPLE_BITS-1:0]   xs_q [DIMS];
  logic signed [SAMPLE_BITS-1:0]   mn_q, mx_q, bl_q;
  logic signed [EXT_W-1:0]         xe, mne, mxe, ble, lo, hi, diff;

  logic [DIV_W-1:0]                div_r_q, div_rs;
  logic [DIV_W-2:0]                div_d_q;
  logic [Q16_W-1:0]                div_q_q;
  logic                            div_ge;

  logic [31:0]                     tt_q;
  logic [17:0]                     coef;
  logic [49:0]                     sm_prod;
  logic [Q16_W-1:0]                ramp_q, rise_q, fall_q, mw_q, m_q;
  logic [33:0]                     mw_prod, chain_prod;
  logic [47:0]                     w_prod;
  logic                            prio_pos;
  logic [SAMPLE_BITS-1:0]          w_q;

  logic [SAMPLE_BITS-1:0]          rw_q [TOP_SLOTS];
  logic [IDX_W-1:0]                ri_q [TOP_SLOTS];
  logic [SAMPLE_BITS-1:0]          rw_n [TOP_SLOTS];
  logic [IDX_W-1:0]                ri_n [TOP_SLOTS];
  logic [NW_W-1:0]                 nq_q [TOP_SLOTS];
  logic [CNT_W-1:0]                count_q, pos;
  logic [TOTAL_W-1:0]              total_q;
  logic                            out_valid_q;
  logic [OUT_DATA_W-1:0]           out_data_q;
  logic [IDX_W-1:0]                dominant;

  // table addressing
  assign wr_en = cmd_i.wr && (32'(entry_index_i) < 32'(MAX_ENTRIES))
                 && (param_select_i < SEL_W'(PARAMS_PER_ENTRY));
  assign waddr = ADDR_W'(ADDR_W'(entry_index_i) * ADDR_W'(PARAMS_PER_ENTRY)
                 + ADDR_W'(param_select_i));
  assign raddr = ADDR_W'(ADDR_W'(entry_i) * ADDR_W'(PARAMS_PER_ENTRY) + ADDR_W'(cmd_i.sel));

  // parameter table, registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) mem[waddr] <= param_value_i;
    if (cmd_i.rd) rdata_q <= mem[raddr];
  end

  // ramp bounds for the rising or falling edge of the window
  always_comb begin
    xe   = EXT_W'(xs_q[cmd_i.dim]);
    mne  = EXT_W'(mn_q);
    mxe  = EXT_W'(mx_q);
    ble  = EXT_W'(bl_q);
    lo   = cmd_i.phase ? (mxe - ble) : mne;
    hi   = cmd_i.phase ? mxe : (mne + ble);
    diff = xe - lo;
  end

  // divider step, one quotient bit per cycle
  assign div_ge = div_r_q >= {1'b0, div_d_q};
  assign div_rs = div_ge ? (div_r_q - {1'b0, div_d_q}) : div_r_q;

  // products
  assign coef       = SMOOTH_K - {1'b0, div_q_q[NW_W-1:0], 1'b0};
  assign sm_prod    = 50'(tt_q) * 50'(coef);
  assign mw_prod    = 34'(rise_q) * 34'(fall_q);
  assign chain_prod = 34'(m_q) * 34'(mw_q);
  assign prio_pos   = !rdata_q[SAMPLE_BITS-1] && (rdata_q != '0);
  assign w_prod     = 48'(m_q) * 48'(rdata_q[SAMPLE_BITS-2:0]);

  // rank slot for the new weight, earlier entry wins a tie
  always_comb begin
    pos = '0;
    for (int s = 0; s < TOP_SLOTS; s++) begin
      if ((CNT_W'(s) < count_q) && (w_q <= rw_q[s])) pos = pos + CNT_W'(1);
    end
    rw_n = rw_q;
    ri_n = ri_q;
    for (int s = 1; s < TOP_SLOTS; s++) begin
      if (CNT_W'(s) > pos) begin
        rw_n[s] = rw_q[s-1];
        ri_n[s] = ri_q[s-1];
      end
    end
    for (int s = 0; s < TOP_SLOTS; s++) begin
      if (CNT_W'(s) == pos) begin
        rw_n[s] = w_q;
        ri_n[s] = IDX_W'(entry_i);
      end
    end
  end

  // arithmetic and ranking registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      xs_q[0] <= temperature_i;
      xs_q[1] <= humidity_i;
      xs_q[2] <= elevation_i;
      xs_q[3] <= steepness_i;
      m_q     <= ONE_Q16;
      count_q <= '0;
      total_q <= '0;
      for (int s = 0; s < TOP_SLOTS; s++) begin
        rw_q[s] <= '0;
        ri_q[s] <= '0;
        nq_q[s] <= '0;
      end
    end
    if (cmd_i.ld_min) mn_q <= rdata_q;
    if (cmd_i.ld_max) mx_q <= rdata_q;
    if (cmd_i.ld_bl)  bl_q <= rdata_q;
    if (cmd_i.hard) mw_q <= ((xe >= mne) && (xe <= mxe)) ? ONE_Q16 : '0;
    if (cmd_i.ramp_sat) ramp_q <= (xe >= hi) ? ONE_Q16 : '0;
    if (cmd_i.div_ramp) begin
      div_r_q <= DIV_W'(diff);
      div_d_q <= (DIV_W-1)'(bl_q);
      div_q_q <= '0;
    end
    if (cmd_i.div_norm) begin
      div_r_q <= DIV_W'(rw_q[cmd_i.slot]);
      div_d_q <= total_q;
      div_q_q <= '0;
    end
    if (cmd_i.div_step) begin
      div_r_q <= {div_rs[DIV_W-2:0], 1'b0};
      div_q_q <= {div_q_q[Q16_W-2:0], div_ge};
    end
    if (cmd_i.sq) tt_q <= 32'(div_q_q[NW_W-1:0]) * 32'(div_q_q[NW_W-1:0]);
    if (cmd_i.smooth) ramp_q <= sm_prod[48:32];
    if (cmd_i.ramp_end) begin
      if (!cmd_i.phase) rise_q <= ramp_q;
      else fall_q <= ONE_Q16 - ramp_q;
    end
    if (cmd_i.mw) mw_q <= mw_prod[32:16];
    if (cmd_i.chain) m_q <= chain_prod[32:16];
    if (cmd_i.m_init) m_q <= ONE_Q16;
    if (cmd_i.weight) w_q <= prio_pos ? w_prod[47:16] : '0;
    if (cmd_i.insert && (w_q != '0) && (pos < CNT_W'(TOP_SLOTS))) begin
      rw_q <= rw_n;
      ri_q <= ri_n;
      if (count_q < CNT_W'(TOP_SLOTS)) count_q <= count_q + CNT_W'(1);
    end
    if (cmd_i.sum_add) total_q <= total_q + TOTAL_W'(rw_q[cmd_i.slot]);
    if (cmd_i.norm_store) nq_q[cmd_i.slot] <= div_q_q[Q16_W-1] ? '1 : div_q_q[NW_W-1:0];
    if (cmd_i.norm_zero) nq_q[cmd_i.slot] <= '0;
    if (cmd_i.out_load) out_data_q <= {1'b0, nq_q[3], nq_q[2], nq_q[1], nq_q[0],
                                       ri_q[3], ri_q[2], ri_q[1], ri_q[0], dominant, count_q};
  end

  assign dominant = (count_q != '0) ? ri_q[0] : '0;

  // output item register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // status back to the sequencer
  always_comb begin
    status_o.bl_pos     = !bl_q[SAMPLE_BITS-1] && (bl_q != '0);
    status_o.ramp_low   = xe <= lo;
    status_o.ramp_high  = xe >= hi;
    status_o.chain_zero = chain_prod[32:16] == '0;
    status_o.count      = count_q;
    status_o.out_free   = !out_valid_q || out_ready_i;
  end

endmodule

FILE: hdl/fuzzy_window_top_k_classifier_top.sv
// top level of the fuzzy window top-k classifier
`timescale 1ns / 1ps
// usage
// - s_axis carries load and classify items; tuser selects: 0 loads one table
//   parameter, 1 classifies four samples. a load brings no result.
// - cfg_* writes entry_count; write it only while no classify is in flight.
// - m_axis returns one item per classify, held until m_axis_tready_i.
// processing
// - a classify runs one entry after another through one shared divider that
//   yields a quotient bit per cycle; each dimension has a rising and a falling
//   ramp, and an entry ends early when its membership reaches zero.
// - normalization uses the same divider for each kept slot. one item is worked
//   on at a time.
// reset
// - rst_ni is asynchronous active low; it clears the sequencer, entry_count
//   and the output valid. table entries are undefined until loaded.
// stalls
// - a finished result sits in the output register; the next item is taken
//   while it waits, and a second result waits in the sequencer until the
//   register frees up.
module fuzzy_window_top_k_classifier_top #(
  parameter int MAX_ENTRIES = fwtk_pkg::DEF_MAX_ENTRIES
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // entry_index, param_select, param_value, temperature, humidity, elevation, steepness
  input  logic [fwtk_pkg::IN_DATA_W-1:0]    s_axis_tdata_i,
  // opcode
  input  logic                              s_axis_tuser_i,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // match_count, dominant_index, index_0..3, weight_0..3, zero pad
  output logic [fwtk_pkg::OUT_DATA_W-1:0]   m_axis_tdata_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [fwtk_pkg::CFG_W-1:0]        cfg_data_i
);
  import fwtk_pkg::*;

  localparam int EW = $clog2(MAX_ENTRIES + 1);

  logic [CFG_W-1:0] entry_count_q;
  dp_cmd_t          cmd;
  dp_status_t       status;
  logic [EW-1:0]    entry;

  // configuration register
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_count_q <= '0;
    end else if (cfg_valid_i) begin
      entry_count_q <= cfg_data_i;
    end
  end

  fwtk_ctrl #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .EW          (EW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .opcode_i    (s_axis_tuser_i),
    .cfg_count_i (entry_count_q),
    .status_i    (status),
    .cmd_o       (cmd),
    .entry_o     (entry)
  );

  fwtk_datapath #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .EW          (EW)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .entry_i        (entry),
    .status_o       (status),
    .entry_index_i  (s_axis_tdata_i[3:0]),
    .param_select_i (s_axis_tdata_i[7:4]),
    .param_value_i  (s_axis_tdata_i[39:8]),
    .temperature_i  (s_axis_tdata_i[71:40]),
    .humidity_i     (s_axis_tdata_i[103:72]),
    .elevation_i    (s_axis_tdata_i[135:104]),
    .steepness_i    (s_axis_tdata_i[167:136]),
    .out_ready_i    (m_axis_tready_i),
    .out_valid_o    (m_axis_tvalid_o),
    .out_data_o     (m_axis_tdata_o)
  );

endmodule

FILE: hdl/fwtk_checker.sv
// port level checks of the classifier, bound to the top level
`timescale 1ns / 1ps
module fwtk_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid_i,
  input logic                            s_axis_tready_o,
  input logic                            s_axis_tuser_i,
  input logic                            m_axis_tvalid_o,
  input logic                            m_axis_tready_i,
  input logic [fwtk_pkg::OUT_DATA_W-1:0] m_axis_tdata_o
);
  import fwtk_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> $stable(m_axis_tdata_o))
    else $error("result changed while stalled");

  // a load item never brings a result
  a_load_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && !s_axis_tuser_i && !m_axis_tvalid_o
    |=> !m_axis_tvalid_o)
    else $error("result after a load item");

  // a classify item keeps the input side busy
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && s_axis_tuser_i |=> !s_axis_tready_o)
    else $error("input taken during a classify");

  // kept count never exceeds the slot count
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[CNT_W-1:0] <= CNT_W'(TOP_SLOTS))
    else $error("match count out of range");

endmodule

bind fuzzy_window_top_k_classifier_top fwtk_checker u_fwtk_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tuser_i  (s_axis_tuser_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);
